// ===== hdl/assert_macros.svh =====
// Assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mfog_pkg.sv =====
package mfog_pkg;

    localparam int DIM_MAX_DEF = 128;

    localparam int CFG_DIM_W = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 7;
    localparam int VAL_W     = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_SNAKE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CCW   = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [VAL_W-1:0] cell_value;
        logic             last;
    } result_t;

endpackage

// ===== hdl/mfog_walker.sv =====
module mfog_walker #(
    parameter int DIM_MAX = mfog_pkg::DIM_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           restart,
    input  logic [mfog_pkg::CFG_DIM_W-1:0] row_count,
    input  logic [mfog_pkg::CFG_DIM_W-1:0] col_count,
    input  logic [mfog_pkg::MODE_W-1:0]    fill_mode,
    output mfog_pkg::result_t              res
);
    import mfog_pkg::*;

    // Dims never exceed the 8-bit register range.
    localparam int DMAX = (DIM_MAX < 255) ? DIM_MAX : 255;
    localparam int DW   = $clog2(DMAX + 1);
    localparam int TW   = $clog2(DMAX * DMAX + 1);
    // Extra bit keeps wrapped ring bounds ordered above any real coordinate.
    localparam int CW   = TW + 1;

    typedef enum logic [1:0] {HEAD_ALONG, HEAD_DOWN, HEAD_BACK, HEAD_UP} heading_t;

    logic [CW-1:0] row_reg, col_reg, top_reg, bot_reg, left_reg, right_reg;
    logic [TW-1:0] done_reg;
    heading_t      head_reg;
    logic          open_reg;

    logic [CW-1:0] row_next, col_next, top_next, bot_next, left_next, right_next;
    logic [TW-1:0] done_next;
    heading_t      head_next;

    logic [CW-1:0] s_row, s_col, s_top, s_bot, s_left, s_right;
    logic [TW-1:0] s_done;
    heading_t      s_head;

    logic [DW-1:0]   rows, cols;
    logic [2*DW-1:0] prod;
    logic [TW-1:0]   total;
    logic            fresh;

    always_comb
    begin
        if (row_count == '0)
            rows = DW'(1);
        else if (int'(row_count) > DIM_MAX)
            rows = DW'(DMAX);
        else
            rows = DW'(row_count);
        if (col_count == '0)
            cols = DW'(1);
        else if (int'(col_count) > DIM_MAX)
            cols = DW'(DMAX);
        else
            cols = DW'(col_count);
    end

    assign prod  = (2*DW)'(rows) * (2*DW)'(cols);
    assign total = TW'(prod);

    assign fresh = restart || !open_reg || (done_reg >= total) ||
                   (row_reg >= CW'(rows)) || (col_reg >= CW'(cols));

    always_comb
    begin
        if (fresh)
        begin
            s_done  = '0;
            s_top   = '0;
            s_bot   = CW'(rows) - CW'(1);
            s_left  = '0;
            s_right = CW'(cols) - CW'(1);
            s_head  = HEAD_ALONG;
            s_row   = '0;
            s_col   = (fill_mode == MODE_CCW) ? CW'(cols) - CW'(1) : '0;
        end
        else
        begin
            s_done  = done_reg;
            s_top   = top_reg;
            s_bot   = bot_reg;
            s_left  = left_reg;
            s_right = right_reg;
            s_head  = head_reg;
            s_row   = row_reg;
            s_col   = col_reg;
        end
    end

    always_comb
    begin
        res.row_index  = IDX_W'(s_row);
        res.col_index  = IDX_W'(s_col);
        res.cell_value = (fill_mode == MODE_CCW) ? VAL_W'(total - s_done)
                                                 : VAL_W'(s_done + TW'(1));
        res.last       = ((s_done + TW'(1)) == total);
    end

    always_comb
    begin
        done_next  = s_done + TW'(1);
        row_next   = s_row;
        col_next   = s_col;
        top_next   = s_top;
        bot_next   = s_bot;
        left_next  = s_left;
        right_next = s_right;
        head_next  = s_head;
        priority if (fill_mode == MODE_CW)
        begin
            unique case (s_head)
                HEAD_ALONG:
                    if (s_col < s_right)
                        col_next = s_col + CW'(1);
                    else
                    begin
                        top_next  = s_top + CW'(1);
                        head_next = HEAD_DOWN;
                        row_next  = s_row + CW'(1);
                    end
                HEAD_DOWN:
                    if (s_row < s_bot)
                        row_next = s_row + CW'(1);
                    else
                    begin
                        right_next = s_right - CW'(1);
                        head_next  = HEAD_BACK;
                        col_next   = s_col - CW'(1);
                    end
                HEAD_BACK:
                    if (s_col > s_left)
                        col_next = s_col - CW'(1);
                    else
                    begin
                        bot_next  = s_bot - CW'(1);
                        head_next = HEAD_UP;
                        row_next  = s_row - CW'(1);
                    end
                default:
                    if (s_row > s_top)
                        row_next = s_row - CW'(1);
                    else
                    begin
                        left_next = s_left + CW'(1);
                        head_next = HEAD_ALONG;
                        col_next  = s_col + CW'(1);
                    end
            endcase
        end
        else if (fill_mode == MODE_CCW)
        begin
            unique case (s_head)
                HEAD_ALONG:
                    if (s_col > s_left)
                        col_next = s_col - CW'(1);
                    else
                    begin
                        top_next  = s_top + CW'(1);
                        head_next = HEAD_DOWN;
                        row_next  = s_row + CW'(1);
                    end
                HEAD_DOWN:
                    if (s_row < s_bot)
                        row_next = s_row + CW'(1);
                    else
                    begin
                        left_next = s_left + CW'(1);
                        head_next = HEAD_BACK;
                        col_next  = s_col + CW'(1);
                    end
                HEAD_BACK:
                    if (s_col < s_right)
                        col_next = s_col + CW'(1);
                    else
                    begin
                        bot_next  = s_bot - CW'(1);
                        head_next = HEAD_UP;
                        row_next  = s_row - CW'(1);
                    end
                default:
                    if (s_row > s_top)
                        row_next = s_row - CW'(1);
                    else
                    begin
                        right_next = s_right - CW'(1);
                        head_next  = HEAD_ALONG;
                        col_next   = s_col - CW'(1);
                    end
            endcase
        end
        else
        begin
            // snake; unused mode code also lands here
            if (!s_row[0])
            begin
                if ((s_col + CW'(1)) < CW'(cols))
                    col_next = s_col + CW'(1);
                else
                    row_next = s_row + CW'(1);
            end
            else
            begin
                if (s_col != '0)
                    col_next = s_col - CW'(1);
                else
                    row_next = s_row + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            top_reg   <= '0;
            bot_reg   <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            done_reg  <= '0;
            head_reg  <= HEAD_ALONG;
            open_reg  <= 1'b0;
        end
        else if (advance)
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            top_reg   <= top_next;
            bot_reg   <= bot_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            done_reg  <= done_next;
            head_reg  <= head_next;
            open_reg  <= 1'b1;
        end
    end

endmodule

// ===== hdl/matrix_fill_order_generator_core.sv =====
// Matrix fill order generator: emits one cell position of a rows-by-cols
// matrix per input item, as a snake, a clockwise ascending spiral or a
// counter-clockwise descending spiral.
// Input channel: in_valid / in_stall carrying restart. restart = 1 begins a
// new pass at its first cell; 0 steps to the next cell. A step after the last
// cell of a pass also begins a new pass.
// Output channel: out_valid / out_stall carrying row_index, col_index,
// cell_value and last (high on the final cell of a pass).
// Config channel: cfg_valid / cfg_ready, cfg_index 0 rows, 1 cols, 2 mode;
// cfg_ready is always high. Write only while no item is in flight.
// Result is registered; a held output parks new items in the skid register.
// Throughput: one item per cycle while in_stall is low; the whole step is
// one combinational pass through the walker from state to result registers.
// Stall: a two-entry output (result register plus skid register) keeps
// accepting while the receiver stalls; in_stall rises once both are full.
// Reset: 1x1 matrix, snake mode, no pass open, output empty.
module matrix_fill_order_generator_core #(
    parameter int DIM_MAX = mfog_pkg::DIM_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mfog_pkg::IDX_W-1:0]     row_index,
    output logic [mfog_pkg::IDX_W-1:0]     col_index,
    output logic [mfog_pkg::VAL_W-1:0]     cell_value,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mfog_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfog_pkg::CFG_DIM_W-1:0] cfg_data
);
    import mfog_pkg::*;

    `include "assert_macros.svh"

    logic [CFG_DIM_W-1:0] row_count_reg, col_count_reg;
    logic [MODE_W-1:0]    fill_mode_reg;

    result_t step_res;
    result_t out_res_reg, skid_res_reg;
    logic    out_valid_reg, skid_full_reg;
    logic    accept, out_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_full_reg;
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CFG_DIM_W'(1);
            col_count_reg <= CFG_DIM_W'(1);
            fill_mode_reg <= MODE_SNAKE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT: row_count_reg <= cfg_data;
                CFG_COL_COUNT: col_count_reg <= cfg_data;
                CFG_FILL_MODE: fill_mode_reg <= cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    mfog_walker #(
        .DIM_MAX(DIM_MAX)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .restart   (restart),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .fill_mode (fill_mode_reg),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_take)
                skid_full_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
                skid_full_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (out_take)
                out_res_reg <= skid_res_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
                skid_res_reg <= step_res;
            else
                out_res_reg <= step_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_index  = out_res_reg.row_index;
    assign col_index  = out_res_reg.col_index;
    assign cell_value = out_res_reg.cell_value;
    assign last       = out_res_reg.last;

    `ASSERT_SAME(a_skid_needs_out, skid_full_reg, out_valid_reg,
        "skid holds an item while the result register is empty")
    `ASSERT_NEXT(a_accept_gives_out, accept, out_valid_reg,
        "accepted item left no result")
    `ASSERT_NEXT(a_held_accept_fills_skid, accept && out_valid_reg && out_stall,
        skid_full_reg, "item accepted under stall was not parked in skid")

endmodule
